// ===== rtl/core/cea_pkg.sv =====
// Shared types, constants and state codes of the cluster extent accumulator.
package cea_pkg;

	localparam int MAX_CLUSTERS_DEF = 64;
	localparam int COUNT_BITS_DEF   = 16;
	localparam int POS_W   = 20;
	localparam int RNG_W   = 20;
	localparam int ANG_W   = 16;
	localparam int OCNT_W  = 16;
	localparam int CFG_W   = 16;
	localparam int ID_W    = 7;

	localparam logic CFG_MIN_POINTS = 1'b0;
	localparam logic CFG_MAX_POINTS = 1'b1;

	typedef struct packed {
		logic signed [POS_W-1:0] xlo;
		logic signed [POS_W-1:0] xhi;
		logic signed [POS_W-1:0] ylo;
		logic signed [POS_W-1:0] yhi;
		logic        [RNG_W-1:0] rlo;
		logic        [RNG_W-1:0] rhi;
		logic signed [ANG_W-1:0] alo;
		logic signed [ANG_W-1:0] ahi;
	} ext_t;

	localparam ext_t EXT_RESET = '{
		xlo: {1'b0, {(POS_W-1){1'b1}}},
		xhi: {1'b1, {(POS_W-1){1'b0}}},
		ylo: {1'b0, {(POS_W-1){1'b1}}},
		yhi: {1'b1, {(POS_W-1){1'b0}}},
		rlo: {RNG_W{1'b1}},
		rhi: '0,
		alo: {1'b0, {(ANG_W-1){1'b1}}},
		ahi: {1'b1, {(ANG_W-1){1'b0}}}
	};

	typedef struct packed {
		logic [OCNT_W-1:0]       cnt;
		ext_t                    ext;
		logic signed [POS_W-1:0] avg_x;
		logic signed [POS_W-1:0] avg_y;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_FL_RD,
		ST_FL_CHK,
		ST_FL_DIV,
		ST_FL_SAVE,
		ST_FL_END
	} st_t;

	typedef struct packed {
		logic acc_load;
		logic acc_write;
		logic use_idx;
		logic idx_clr;
		logic idx_inc;
		logic div_start;
		logic div_step;
		logic pend_load;
		logic flush_clr;
	} cmd_t;

	typedef struct packed {
		logic id_ok;
		logic qualify;
		logic div_done;
		logic idx_last;
		logic pend_vld;
	} sts_t;

endpackage

// ===== rtl/core/cea_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/cea_datapath.sv =====
// Datapath: cluster table, update logic, size check, mean divider, report register.
module cea_datapath
	import cea_pkg::*;
#(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic signed [ID_W-1:0]  cluster_id,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic [RNG_W-1:0]        peak_range,
	input  logic signed [ANG_W-1:0] peak_angle,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output res_t                    res
);

	localparam int AW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int SW    = POS_W + COUNT_BITS;
	localparam int REC_W = COUNT_BITS + 2 * SW + $bits(ext_t);
	localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam int STW   = $clog2(SW + 1);

	logic [CFG_W-1:0] min_q, max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= CFG_W'(1);
			max_q <= {CFG_W{1'b1}};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_POINTS: min_q <= cfg_data;
				CFG_MAX_POINTS: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched peak
	logic [AW-1:0]           id_q;
	logic signed [POS_W-1:0] x_q, y_q;
	logic [RNG_W-1:0]        r_q;
	logic signed [ANG_W-1:0] a_q;

	logic [5:0] id_u;
	assign id_u = cluster_id[5:0];
	assign sts.id_ok = !cluster_id[ID_W-1] && ({1'b0, id_u} < 7'(MAX_CLUSTERS));

	always_ff @(posedge clk) begin
		if (cmd.acc_load) begin
			id_q <= id_u[AW-1:0];
			x_q  <= pos_x;
			y_q  <= pos_y;
			r_q  <= peak_range;
			a_q  <= peak_angle;
		end
	end

	logic [AW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end
	assign sts.idx_last = (idx_q == AW'(MAX_CLUSTERS - 1));

	// table memory, valid bits stand in for the cleared state
	logic [AW-1:0]    raddr;
	logic [REC_W-1:0] rdata, wdata;
	logic             we;
	logic             vld_q [MAX_CLUSTERS];
	logic             rd_vld_s1;

	assign raddr = cmd.use_idx ? idx_q : id_u[AW-1:0];
	assign we    = cmd.acc_write;

	cea_ram #(.WIDTH(REC_W), .DEPTH(MAX_CLUSTERS), .AW(AW)) u_tab (
		.clk   (clk),
		.we    (we),
		.waddr (id_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) vld_q[i] <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[raddr];
			if (cmd.flush_clr) begin
				for (int i = 0; i < MAX_CLUSTERS; i++) vld_q[i] <= 1'b0;
			end else if (we) begin
				vld_q[id_q] <= 1'b1;
			end
		end
	end

	logic [COUNT_BITS-1:0] rd_cnt;
	logic signed [SW-1:0]  rd_sx, rd_sy;
	ext_t                  rd_ext;

	always_comb begin
		if (rd_vld_s1) begin
			{rd_cnt, rd_sx, rd_sy, rd_ext} = rdata;
		end else begin
			rd_cnt = '0;
			rd_sx  = '0;
			rd_sy  = '0;
			rd_ext = EXT_RESET;
		end
	end

	// accumulate update; a saturated count freezes count and sums
	logic                  sat;
	logic [COUNT_BITS-1:0] nw_cnt;
	logic signed [SW-1:0]  nw_sx, nw_sy;
	ext_t                  nw_ext;

	always_comb begin
		sat    = (rd_cnt == {COUNT_BITS{1'b1}});
		nw_cnt = sat ? rd_cnt : rd_cnt + 1'b1;
		nw_sx  = sat ? rd_sx : rd_sx + SW'(x_q);
		nw_sy  = sat ? rd_sy : rd_sy + SW'(y_q);
		nw_ext = rd_ext;
		if (x_q < rd_ext.xlo) nw_ext.xlo = x_q;
		if (x_q > rd_ext.xhi) nw_ext.xhi = x_q;
		if (y_q < rd_ext.ylo) nw_ext.ylo = y_q;
		if (y_q > rd_ext.yhi) nw_ext.yhi = y_q;
		if (r_q < rd_ext.rlo) nw_ext.rlo = r_q;
		if (r_q > rd_ext.rhi) nw_ext.rhi = r_q;
		if (a_q < rd_ext.alo) nw_ext.alo = a_q;
		if (a_q > rd_ext.ahi) nw_ext.ahi = a_q;
		wdata = {nw_cnt, nw_sx, nw_sy, nw_ext};
	end

	logic [CMP_W-1:0] cnt_w;
	assign cnt_w = CMP_W'(rd_cnt);
	assign sts.qualify = (rd_cnt != '0) && (cnt_w >= CMP_W'(min_q)) && (cnt_w <= CMP_W'(max_q));

	// restoring divider on magnitudes, x and y in lockstep
	logic                  neg_x_q, neg_y_q;
	logic [SW-1:0]         qx_q, qy_q;
	logic [COUNT_BITS-1:0] rx_q, ry_q, dvs_q;
	logic [STW-1:0]        step_q;
	logic [COUNT_BITS:0]   rx_sh, ry_sh;
	logic                  gx, gy;

	assign rx_sh = {rx_q, qx_q[SW-1]};
	assign ry_sh = {ry_q, qy_q[SW-1]};
	assign gx    = rx_sh >= {1'b0, dvs_q};
	assign gy    = ry_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_start) begin
			step_q <= STW'(SW);
		end else if (cmd.div_step) begin
			step_q <= step_q - 1'b1;
		end
	end
	assign sts.div_done = (step_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_x_q <= rd_sx[SW-1];
			neg_y_q <= rd_sy[SW-1];
			qx_q    <= rd_sx[SW-1] ? SW'(-rd_sx) : SW'(rd_sx);
			qy_q    <= rd_sy[SW-1] ? SW'(-rd_sy) : SW'(rd_sy);
			rx_q    <= '0;
			ry_q    <= '0;
			dvs_q   <= rd_cnt;
		end else if (cmd.div_step) begin
			rx_q <= gx ? COUNT_BITS'(rx_sh - {1'b0, dvs_q}) : rx_sh[COUNT_BITS-1:0];
			ry_q <= gy ? COUNT_BITS'(ry_sh - {1'b0, dvs_q}) : ry_sh[COUNT_BITS-1:0];
			qx_q <= {qx_q[SW-2:0], gx};
			qy_q <= {qy_q[SW-2:0], gy};
		end
	end

	logic [SW-1:0] sq_x, sq_y;
	assign sq_x = neg_x_q ? SW'(-qx_q) : qx_q;
	assign sq_y = neg_y_q ? SW'(-qy_q) : qy_q;

	// report held until the next one shows whether it is the final one
	logic pend_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.flush_clr) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.pend_load) begin
			pend_vld_q <= 1'b1;
		end
	end
	assign sts.pend_vld = pend_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.pend_load) begin
			res.cnt   <= (cnt_w > CMP_W'({OCNT_W{1'b1}})) ? {OCNT_W{1'b1}} : cnt_w[OCNT_W-1:0];
			res.ext   <= rd_ext;
			res.avg_x <= sq_x[POS_W-1:0];
			res.avg_y <= sq_y[POS_W-1:0];
		end
	end

endmodule

// ===== rtl/core/cea_ctrl.sv =====
// Controller state machine: accumulate and flush sequencing.
module cea_ctrl
	import cea_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic action,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic result_valid,
	output logic last
);

	st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (action) state_d = ST_FL_RD;
					else if (sts.id_ok) state_d = ST_ACC;
				end
			end
			ST_ACC:    state_d = ST_IDLE;
			ST_FL_RD:  state_d = ST_FL_CHK;
			ST_FL_CHK: begin
				if (sts.qualify) state_d = ST_FL_DIV;
				else if (sts.idx_last) state_d = ST_FL_END;
				else state_d = ST_FL_RD;
			end
			ST_FL_DIV: if (sts.div_done) state_d = ST_FL_SAVE;
			ST_FL_SAVE: state_d = sts.idx_last ? ST_FL_END : ST_FL_RD;
			ST_FL_END: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		busy         = 1'b1;
		result_valid = 1'b0;
		last         = 1'b0;
		cmd.use_idx  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy         = 1'b0;
				cmd.use_idx  = 1'b0;
				cmd.acc_load = start && !action;
				cmd.idx_clr  = start && action;
			end
			ST_ACC:    cmd.acc_write = 1'b1;
			ST_FL_RD:  ;
			ST_FL_CHK: begin
				cmd.div_start = sts.qualify;
				cmd.idx_inc   = !sts.qualify && !sts.idx_last;
			end
			ST_FL_DIV: cmd.div_step = !sts.div_done;
			ST_FL_SAVE: begin
				result_valid  = sts.pend_vld;
				cmd.pend_load = 1'b1;
				cmd.idx_inc   = !sts.idx_last;
			end
			ST_FL_END: begin
				result_valid  = sts.pend_vld;
				last          = 1'b1;
				cmd.flush_clr = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/cluster_extent_accumulator_core.sv =====
// Top level of the cluster extent accumulator.
// Accumulate: valid-id item taken when start && !busy, then busy (table read, then write back).
// Flush: each id read and checked, each reported cluster also runs the bit-serial mean
//   divider, then a closing step; reports lag one qualifying cluster, final one carries last.
// Results appear for one cycle on result_valid; the receiver cannot stall.
// Reset (arst_n low, async): table empty via per-entry valid bits, min_points=1, max_points=65535.
module cluster_extent_accumulator_core
	import cea_pkg::*;
#(
	parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// command channel
	input  logic                     start,
	output logic                     busy,
	input  logic                     action,
	input  logic signed [ID_W-1:0]   cluster_id,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic [RNG_W-1:0]         peak_range,
	input  logic signed [ANG_W-1:0]  peak_angle,
	// configuration
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	// results
	output logic                     result_valid,
	output logic [OCNT_W-1:0]        point_count,
	output logic signed [POS_W-1:0]  min_x,
	output logic signed [POS_W-1:0]  max_x,
	output logic signed [POS_W-1:0]  min_y,
	output logic signed [POS_W-1:0]  max_y,
	output logic [RNG_W-1:0]         min_rng,
	output logic [RNG_W-1:0]         max_rng,
	output logic signed [ANG_W-1:0]  min_ang,
	output logic signed [ANG_W-1:0]  max_ang,
	output logic signed [POS_W-1:0]  avg_x,
	output logic signed [POS_W-1:0]  avg_y,
	output logic                     last
);

	cmd_t cmd;
	sts_t sts;
	res_t res;

	// registers are always writable; user must write only while idle, not enforced here
	assign cfg_ready = 1'b1;

	cea_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid),
		.last         (last)
	);

	cea_datapath #(.MAX_CLUSTERS(MAX_CLUSTERS), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cluster_id (cluster_id),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.peak_range (peak_range),
		.peak_angle (peak_angle),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res        (res)
	);

	// held report fields
	assign point_count = res.cnt;
	assign min_x       = res.ext.xlo;
	assign max_x       = res.ext.xhi;
	assign min_y       = res.ext.ylo;
	assign max_y       = res.ext.yhi;
	assign min_rng     = res.ext.rlo;
	assign max_rng     = res.ext.rhi;
	assign min_ang     = res.ext.alo;
	assign max_ang     = res.ext.ahi;
	assign avg_x       = res.avg_x;
	assign avg_y       = res.avg_y;

endmodule
